// ===== rtl/ratiometric_voltage_statistics_macros.svh =====
// assertion macros for the ratiometric voltage statistics block
`ifndef RATIOMETRIC_VOLTAGE_STATISTICS_MACROS_SVH
`define RATIOMETRIC_VOLTAGE_STATISTICS_MACROS_SVH

// same-cycle implication, disabled during reset
`define RVS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define RVS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/rvs_pkg.sv =====
// types, constants and widths shared by the voltage statistics block
`timescale 1ns / 1ps

package rvs_pkg;

  // converter resolution in bits
  localparam int unsigned ADC_BITS = 10;

  localparam int unsigned RD_W    = 10;
  localparam int unsigned SCALE_W = 10;
  localparam int unsigned VOLT_W  = 16;
  localparam int unsigned SUM_W   = 48;
  localparam int unsigned CNT_W   = 32;

  localparam int unsigned RD_BITS = (ADC_BITS < RD_W) ? ADC_BITS : RD_W;
  localparam logic [RD_W-1:0] RD_MASK = {RD_W{1'b1}} >> (RD_W - RD_BITS);

  localparam int unsigned TOT_W  = RD_W + 2;
  localparam int unsigned PROD_W = TOT_W + SCALE_W;

  // shared divider geometry
  localparam int unsigned DIV_W  = PROD_W - 2;
  localparam int unsigned REM_W  = CNT_W;
  localparam int unsigned STEP_W = $clog2(DIV_W + 1);
  localparam int unsigned AVG_STEPS = VOLT_W;

  localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(120);
  localparam logic [VOLT_W-1:0]  VOLT_MAX    = {VOLT_W{1'b1}};
  localparam logic [CNT_W-1:0]   COUNT_FULL  = {CNT_W{1'b1}};
  localparam logic [REM_W-1:0]   READINGS    = REM_W'(3);

  // divide by three as a reciprocal multiply, exact for products below 2^23
  localparam int unsigned RECIP_SH = 23;
  localparam int unsigned RECIP_W  = RECIP_SH + DIV_W;
  localparam logic [PROD_W-1:0] RECIP3 =
    PROD_W'(((64'd1 << RECIP_SH) + 64'(READINGS) - 64'd1) / 64'(READINGS));

  typedef struct packed {
    logic              start;
    logic [REM_W-1:0]  rem_init;
    logic [DIV_W-1:0]  dividend;
    logic [REM_W-1:0]  divisor;
    logic [STEP_W-1:0] steps;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_sts_t;

endpackage

// ===== rtl/rvs_in_if.sv =====
// input request channel of the voltage statistics block
`timescale 1ns / 1ps

interface rvs_in_if
  import rvs_pkg::*;
;
  logic            valid;
  logic            ready;
  logic            clear_totals;
  logic [RD_W-1:0] sample_a;
  logic [RD_W-1:0] sample_b;
  logic [RD_W-1:0] sample_c;
  logic [RD_W-1:0] ref_sample;

  modport source (
    output valid, clear_totals, sample_a, sample_b, sample_c, ref_sample,
    input  ready
  );
  modport sink (
    input  valid, clear_totals, sample_a, sample_b, sample_c, ref_sample,
    output ready
  );
endinterface

// ===== rtl/rvs_out_if.sv =====
// result channel of the voltage statistics block
`timescale 1ns / 1ps

interface rvs_out_if
  import rvs_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [VOLT_W-1:0] volts_now;
  logic [VOLT_W-1:0] volts_min;
  logic [VOLT_W-1:0] volts_max;
  logic [VOLT_W-1:0] volts_avg;
  logic              ref_zero;

  modport source (
    output valid, volts_now, volts_min, volts_max, volts_avg, ref_zero,
    input  ready
  );
  modport sink (
    input  valid, volts_now, volts_min, volts_max, volts_avg, ref_zero,
    output ready
  );
endinterface

// ===== rtl/rvs_divider.sv =====
// shared restoring divider, one quotient bit per clock
`timescale 1ns / 1ps

module rvs_divider
  import rvs_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_sts_t sts
);

  logic              busy_r;
  logic              done_r;
  logic [STEP_W-1:0] cnt_r;
  logic [REM_W-1:0]  rem_r;
  logic [DIV_W-1:0]  sh_r;
  logic [REM_W-1:0]  divisor_r;

  logic [REM_W:0]   cand;
  logic [REM_W+1:0] diff;
  logic             ge;

  // shift the next dividend bit into the partial remainder and trial-subtract
  assign cand = {rem_r, sh_r[DIV_W-1]};
  assign diff = {1'b0, cand} - {2'b00, divisor_r};
  assign ge   = ~diff[REM_W+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (busy_r) begin
        rem_r <= ge ? diff[REM_W-1:0] : cand[REM_W-1:0];
        sh_r  <= {sh_r[DIV_W-2:0], ge};
        cnt_r <= cnt_r - STEP_W'(1);
        if (cnt_r == STEP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end else if (req.start) begin
        rem_r     <= req.rem_init;
        sh_r      <= req.dividend;
        divisor_r <= req.divisor;
        cnt_r     <= req.steps;
        busy_r    <= 1'b1;
      end
    end
  end

  assign sts.busy     = busy_r;
  assign sts.done     = done_r;
  assign sts.quotient = sh_r;

endmodule

// ===== rtl/ratiometric_voltage_statistics.sv =====
// top level: ratiometric voltage with running minimum, maximum and average
//
// in_chan carries one request: three readings of the measured channel, one
// reading of the internal reference and a clear flag. out_chan returns one
// result per request: present voltage, minimum, maximum, average and the
// zero-reference flag. cfg_we/cfg_wdata write the reference scale; write it
// only while no request is in flight.
// A request takes two passes of the shared one-bit-per-clock divider:
// 20 steps for the divide by the reference reading and 16 for the
// average. The divide by three is a registered reciprocal multiply. A zero
// reference reading skips the first pass. in_chan.ready is high only while
// the sequencer is idle.
// The result sits in an output register: a stalled receiver holds the
// block in its final state but the previous result is kept until taken.
// Reset clears the totals (minimum 65535, maximum 0, sum and count 0) and
// loads the reference scale with 120.
`timescale 1ns / 1ps
`include "ratiometric_voltage_statistics_macros.svh"

module ratiometric_voltage_statistics
  import rvs_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  rvs_in_if.sink             in_chan,
  rvs_out_if.source          out_chan,
  input  logic               cfg_we,
  input  logic [SCALE_W-1:0] cfg_wdata
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_D3,
    S_DR,
    S_UPD,
    S_AVS,
    S_AVW,
    S_FIN
  } state_t;

  state_t             state_r;
  logic [SCALE_W-1:0] scale_r;
  logic [TOT_W-1:0]   total_r;
  logic [RD_W-1:0]    refv_r;
  logic [PROD_W-1:0]  prod_r;
  logic [VOLT_W-1:0]  volts_r;
  logic               zero_r;
  logic [VOLT_W-1:0]  low_r;
  logic [VOLT_W-1:0]  high_r;
  logic [SUM_W-1:0]   sum_r;
  logic [CNT_W-1:0]   count_r;
  logic [VOLT_W-1:0]  avg_r;

  logic               out_valid_r;
  logic [VOLT_W-1:0]  out_now_r;
  logic [VOLT_W-1:0]  out_min_r;
  logic [VOLT_W-1:0]  out_max_r;
  logic [VOLT_W-1:0]  out_avg_r;
  logic               out_zero_r;

  logic [TOT_W-1:0]   total_in;
  logic [PROD_W-1:0]  prod;
  logic [RECIP_W-1:0] prod3;
  logic [DIV_W-1:0]   quot3;
  logic               in_fire;
  div_req_t           div_req;
  div_sts_t           div_sts;

  assign in_fire = in_chan.valid && in_chan.ready;
  assign in_chan.ready = (state_r == S_IDLE);

  assign total_in = TOT_W'(in_chan.sample_a & RD_MASK)
                  + TOT_W'(in_chan.sample_b & RD_MASK)
                  + TOT_W'(in_chan.sample_c & RD_MASK);

  assign prod = PROD_W'(total_r) * PROD_W'(scale_r);

  assign prod3 = RECIP_W'(prod_r) * RECIP_W'(RECIP3);
  assign quot3 = prod3[RECIP_W-1:RECIP_SH];

  always_comb begin
    div_req = '0;
    case (state_r)
      S_D3: begin
        div_req.start    = 1'b1;
        div_req.rem_init = '0;
        div_req.dividend = quot3;
        div_req.divisor  = REM_W'(refv_r);
        div_req.steps    = STEP_W'(DIV_W);
      end
      S_AVS: begin
        // average never exceeds 16 bits, so the upper sum bits seed the remainder
        div_req.start    = 1'b1;
        div_req.rem_init = sum_r[SUM_W-1:AVG_STEPS];
        div_req.dividend = {sum_r[AVG_STEPS-1:0], {(DIV_W - AVG_STEPS){1'b0}}};
        div_req.divisor  = count_r;
        div_req.steps    = STEP_W'(AVG_STEPS);
      end
      default: begin
        div_req = '0;
      end
    endcase
  end

  rvs_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .sts   (div_sts)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      scale_r     <= SCALE_RESET;
      low_r       <= VOLT_MAX;
      high_r      <= '0;
      sum_r       <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        scale_r <= cfg_wdata;
      end
      // the final state loads a new result in the same cycle
      if (out_valid_r && out_chan.ready && (state_r != S_FIN)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            total_r <= total_in;
            refv_r  <= in_chan.ref_sample & RD_MASK;
            if (in_chan.clear_totals) begin
              low_r   <= VOLT_MAX;
              high_r  <= '0;
              sum_r   <= '0;
              count_r <= '0;
            end
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          if (refv_r == '0) begin
            volts_r <= VOLT_MAX;
            zero_r  <= 1'b1;
            state_r <= S_UPD;
          end else begin
            prod_r  <= prod;
            zero_r  <= 1'b0;
            state_r <= S_D3;
          end
        end
        S_D3: begin
          state_r <= S_DR;
        end
        S_DR: begin
          if (div_sts.done) begin
            // saturate quotients above the 16-bit range
            volts_r <= (|div_sts.quotient[DIV_W-1:VOLT_W]) ? VOLT_MAX
                                                           : div_sts.quotient[VOLT_W-1:0];
            state_r <= S_UPD;
          end
        end
        S_UPD: begin
          if (count_r != COUNT_FULL) begin
            sum_r   <= sum_r + SUM_W'(volts_r);
            count_r <= count_r + CNT_W'(1);
          end
          if (volts_r < low_r) begin
            low_r <= volts_r;
          end
          if (volts_r > high_r) begin
            high_r <= volts_r;
          end
          state_r <= S_AVS;
        end
        S_AVS: begin
          state_r <= S_AVW;
        end
        S_AVW: begin
          if (div_sts.done) begin
            avg_r   <= (count_r == '0) ? '0 : div_sts.quotient[VOLT_W-1:0];
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          if (!out_valid_r || out_chan.ready) begin
            out_now_r   <= volts_r;
            out_min_r   <= low_r;
            out_max_r   <= high_r;
            out_avg_r   <= avg_r;
            out_zero_r  <= zero_r;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_chan.valid     = out_valid_r;
  assign out_chan.volts_now = out_now_r;
  assign out_chan.volts_min = out_min_r;
  assign out_chan.volts_max = out_max_r;
  assign out_chan.volts_avg = out_avg_r;
  assign out_chan.ref_zero  = out_zero_r;

  `RVS_ASSERT_NOW(a_ready_div_idle, clk, rst_n, in_chan.ready, !div_sts.busy,
                  "request accepted while divider busy")
  `RVS_ASSERT_NOW(a_done_in_wait, clk, rst_n, div_sts.done,
                  (state_r == S_DR) || (state_r == S_AVW),
                  "divider finished outside a wait state")
  `RVS_ASSERT_NEXT(a_full_holds, clk, rst_n, (state_r == S_UPD) && (count_r == COUNT_FULL),
                   (count_r == COUNT_FULL) && $stable(sum_r), "totals moved with full count")
  `RVS_ASSERT_NOW(a_min_le_max, clk, rst_n, out_chan.valid,
                  out_chan.volts_min <= out_chan.volts_max, "result minimum above maximum")

endmodule

// ===== sim/tb_ratiometric_voltage_statistics.sv =====
// self-checking testbench for the ratiometric voltage statistics block
`timescale 1ns / 1ps

module tb_ratiometric_voltage_statistics;
  import rvs_pkg::*;

  typedef struct packed {
    logic            clear_totals;
    logic [RD_W-1:0] sample_a;
    logic [RD_W-1:0] sample_b;
    logic [RD_W-1:0] sample_c;
    logic [RD_W-1:0] ref_sample;
  } volt_request_t;

  typedef struct packed {
    logic [VOLT_W-1:0] volts_now;
    logic [VOLT_W-1:0] volts_min;
    logic [VOLT_W-1:0] volts_max;
    logic [VOLT_W-1:0] volts_avg;
    logic              ref_zero;
  } volt_result_t;

  class volt_stats_scoreboard;
    logic [SCALE_W-1:0] reference_scale;
    logic [VOLT_W-1:0]  low_mark;
    logic [VOLT_W-1:0]  high_mark;
    logic [SUM_W-1:0]   running_sum;
    logic [CNT_W-1:0]   sample_count;
    volt_result_t       expected_results[$];
    int                 errors;

    function new();
      reference_scale = SCALE_RESET;
      errors = 0;
      clear_totals_now();
    endfunction

    function void clear_totals_now();
      low_mark     = VOLT_MAX;
      high_mark    = '0;
      running_sum  = '0;
      sample_count = '0;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    task report(string what);
      errors++;
      if (errors <= 40) $display("%0t volt stats error: %s", $time, what);
    endtask

    // works out the result of one accepted request and queues it
    function void note_request(volt_request_t r);
      logic [TOT_W-1:0]  total;
      logic [RD_W-1:0]   refv;
      logic [PROD_W-1:0] quotient;
      logic [VOLT_W-1:0] volts;
      logic [SUM_W-1:0]  avg;
      volt_result_t      want;
      if (r.clear_totals) clear_totals_now();
      total = TOT_W'(r.sample_a & RD_MASK) + TOT_W'(r.sample_b & RD_MASK)
            + TOT_W'(r.sample_c & RD_MASK);
      refv = r.ref_sample & RD_MASK;
      if (refv == '0) begin
        volts = VOLT_MAX;
      end else begin
        quotient = (PROD_W'(total) * PROD_W'(reference_scale)) / PROD_W'(READINGS)
                 / PROD_W'(refv);
        volts = (quotient > PROD_W'(VOLT_MAX)) ? VOLT_MAX : VOLT_W'(quotient);
      end
      // totals freeze once the count is full, the marks keep following
      if (sample_count != COUNT_FULL) begin
        running_sum  = running_sum + SUM_W'(volts);
        sample_count = sample_count + CNT_W'(1);
      end
      if (volts < low_mark) low_mark = volts;
      if (volts > high_mark) high_mark = volts;
      avg = (sample_count == '0) ? '0 : running_sum / SUM_W'(sample_count);
      want.volts_now = volts;
      want.volts_min = low_mark;
      want.volts_max = high_mark;
      want.volts_avg = (avg > SUM_W'(VOLT_MAX)) ? VOLT_MAX : VOLT_W'(avg);
      want.ref_zero  = (refv == '0);
      expected_results.push_back(want);
    endfunction

    task check_result(volt_result_t got);
      volt_result_t want;
      if (expected_results.size() == 0) begin
        report($sformatf("result with no request waiting, now=%0d", got.volts_now));
        return;
      end
      want = expected_results.pop_front();
      if (got.volts_now !== want.volts_now)
        report($sformatf("volts_now %0d, expected %0d", got.volts_now, want.volts_now));
      if (got.volts_min !== want.volts_min)
        report($sformatf("volts_min %0d, expected %0d", got.volts_min, want.volts_min));
      if (got.volts_max !== want.volts_max)
        report($sformatf("volts_max %0d, expected %0d", got.volts_max, want.volts_max));
      if (got.volts_avg !== want.volts_avg)
        report($sformatf("volts_avg %0d, expected %0d", got.volts_avg, want.volts_avg));
      if (got.ref_zero !== want.ref_zero)
        report($sformatf("ref_zero %0b, expected %0b", got.ref_zero, want.ref_zero));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [SCALE_W-1:0] cfg_wdata;

  rvs_in_if  in_chan ();
  rvs_out_if out_chan ();

  ratiometric_voltage_statistics uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  volt_stats_scoreboard stats = new();

  int send_idle = 0;
  int recv_idle = 0;
  int send_burst = 0;
  int long_hold_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && in_chan.valid && in_chan.ready)
      stats.note_request('{in_chan.clear_totals, in_chan.sample_a, in_chan.sample_b,
                           in_chan.sample_c, in_chan.ref_sample});
  end

  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready)
      stats.check_result('{out_chan.volts_now, out_chan.volts_min, out_chan.volts_max,
                           out_chan.volts_avg, out_chan.ref_zero});
  end

  // result side: random stalls, clean bursts and one long hold-off on request
  initial begin : receiver
    int hold_left;
    int burst_left;
    hold_left  = 0;
    burst_left = 0;
    out_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_cycles > 0) begin
        hold_left = long_hold_cycles;
        long_hold_cycles = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_chan.ready <= 1'b0;
      end else if (burst_left > 0) begin
        burst_left--;
        out_chan.ready <= 1'b1;
      end else begin
        if ($urandom_range(39) == 0) burst_left = 16;
        out_chan.ready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  function automatic volt_request_t make_request(logic clr, int a, int b, int c, int refv);
    volt_request_t r;
    r.clear_totals = clr;
    r.sample_a     = RD_W'(a);
    r.sample_b     = RD_W'(b);
    r.sample_c     = RD_W'(c);
    r.ref_sample   = RD_W'(refv);
    return r;
  endfunction

  // clears are rare so that the totals run long; readings often sit close together
  function automatic volt_request_t random_request();
    volt_request_t r;
    int pick;
    r.clear_totals = ($urandom_range(29) == 0);
    r.sample_a = RD_W'($urandom_range(1023));
    if ($urandom_range(99) < 40) begin
      r.sample_b = r.sample_a ^ RD_W'($urandom_range(7));
      r.sample_c = r.sample_a ^ RD_W'($urandom_range(7));
    end else begin
      r.sample_b = RD_W'($urandom_range(1023));
      r.sample_c = RD_W'($urandom_range(1023));
    end
    pick = $urandom_range(99);
    if (pick < 3)       r.ref_sample = '0;
    else if (pick < 15) r.ref_sample = RD_W'($urandom_range(31, 1));
    else                r.ref_sample = RD_W'($urandom_range(1023, 32));
    return r;
  endfunction

  task send_request(volt_request_t r);
    if (send_burst > 0) begin
      send_burst--;
    end else begin
      if ($urandom_range(39) == 0) send_burst = 16;
      while ($urandom_range(99) < send_idle) begin
        in_chan.valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_chan.valid        <= 1'b1;
    in_chan.clear_totals <= r.clear_totals;
    in_chan.sample_a     <= r.sample_a;
    in_chan.sample_b     <= r.sample_b;
    in_chan.sample_c     <= r.sample_c;
    in_chan.ref_sample   <= r.ref_sample;
    do @(posedge clk); while (!in_chan.ready);
  endtask

  task wait_idle();
    do @(posedge clk); while (stats.pending() != 0);
  endtask

  // only called while nothing is in flight
  task write_scale(logic [SCALE_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    stats.reference_scale = value;
  endtask

  initial begin : stimulus
    logic [SCALE_W-1:0] scale_plan [8];
    int drain;
    rst_n                <= 1'b0;
    cfg_we               <= 1'b0;
    cfg_wdata            <= '0;
    in_chan.valid        <= 1'b0;
    in_chan.clear_totals <= 1'b0;
    in_chan.sample_a     <= '0;
    in_chan.sample_b     <= '0;
    in_chan.sample_c     <= '0;
    in_chan.ref_sample   <= '0;
    scale_plan = '{10'd1023, 10'd1, SCALE_W'($urandom_range(1023, 1)), 10'd120,
                   SCALE_W'($urandom_range(1023, 1)), 10'd0,
                   SCALE_W'($urandom_range(1023, 1)), 10'd1023};
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed requests at the reset scale
    send_request(make_request(1'b1, 0, 0, 0, 1023));
    send_request(make_request(1'b0, 1023, 1023, 1023, 1));
    send_request(make_request(1'b0, 'h2AA, 'h2AA, 'h2AA, 'h155));
    send_request(make_request(1'b0, 'h155, 'h155, 'h155, 'h2AA));
    send_request(make_request(1'b0, 1023, 1023, 1023, 0));
    send_request(make_request(1'b1, 1023, 1023, 1023, 1023));
    send_request(make_request(1'b0, 0, 0, 0, 0));
    // zero reference as the first sample after a clear
    send_request(make_request(1'b1, 5, 5, 5, 0));
    send_request(make_request(1'b0, 500, 501, 502, 600));
    in_chan.valid <= 1'b0;
    wait_idle();
    // scale of zero: the present voltage reads 0 unless the reference is zero
    write_scale('0);
    send_request(make_request(1'b0, 100, 200, 300, 400));
    send_request(make_request(1'b0, 1, 2, 3, 0));
    send_request(make_request(1'b1, 1023, 1023, 1023, 1));
    in_chan.valid <= 1'b0;
    wait_idle();
    write_scale(10'd1023);
    send_request(make_request(1'b0, 1023, 1023, 1023, 1));
    send_request(make_request(1'b0, 1023, 1023, 1023, 1023));
    send_request(make_request(1'b0, 1, 1, 1, 1023));
    send_request(make_request(1'b1, 2, 0, 0, 1000));
    in_chan.valid <= 1'b0;
    wait_idle();
    write_scale(10'd1);
    send_request(make_request(1'b0, 1023, 1023, 1023, 1));
    send_request(make_request(1'b0, 1, 0, 0, 1));
    in_chan.valid <= 1'b0;

    for (int phase = 0; phase < 8; phase++) begin
      wait_idle();
      write_scale(scale_plan[phase]);
      if (phase < 3) begin
        send_idle = 23;
        recv_idle = 88;
      end else if (phase < 6) begin
        send_idle = 88;
        recv_idle = 23;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      // long receiver hold-off while requests keep coming, so the block backs up
      if (phase == 6) long_hold_cycles = 400;
      for (int i = 0; i < 200; i++) begin
        if (phase == 7 && i == 100) begin
          in_chan.valid <= 1'b0;
          wait_idle();
        end
        send_request(random_request());
      end
      in_chan.valid <= 1'b0;
    end

    drain = 0;
    do begin
      @(posedge clk);
      drain++;
    end while (stats.pending() != 0 && drain < 20000);
    repeat (100) @(posedge clk);
    if (stats.pending() != 0)
      stats.report($sformatf("%0d results never arrived", stats.pending()));
    if (stats.errors == 0) begin
      $display("ratiometric_voltage_statistics: match");
    end else begin
      $display("ratiometric_voltage_statistics: mismatch");
    end
    $finish;
  end

  initial begin : watchdog
    #(64'd10_000_000);
    $display("ratiometric_voltage_statistics: mismatch");
    $finish;
  end

endmodule
